// ----- src/hbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, constants and helpers for the half/bfloat16/single converter.
// ----------------------------------------------------------------------------
package hbs_pkg;

    typedef enum logic [1:0] {
        OP_H2S = 2'd0,
        OP_S2H = 2'd1,
        OP_B2S = 2'd2,
        OP_S2B = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S2H_ZERO = 2'd0,
        S2H_SUB  = 2'd1,
        S2H_NORM = 2'd2,
        S2H_INF  = 2'd3
    } s2h_cls_t;

    localparam logic [7:0]  SINGLE_EXP_MAX   = 8'hFF;
    localparam logic [4:0]  HALF_EXP_MAX     = 5'h1F;
    localparam logic [7:0]  REBIAS           = 8'd112;
    localparam logic [7:0]  SUB_EXP_BASE     = 8'd113;
    localparam logic [7:0]  S2H_SUB_MIN_EXP  = 8'd102;
    localparam logic [7:0]  S2H_OVF_EXP      = 8'd143;
    localparam logic [7:0]  S2H_SHIFT_BASE   = 8'd126;
    localparam logic [14:0] HALF_INF_MAG     = 15'h7C00;

    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [31:0] val;
        logic [3:0]  h_lz;
        s2h_cls_t    s_cls;
        logic [4:0]  s_sh;
    } dec_t;

    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [31:0] val;
        logic [3:0]  h_lz;
        s2h_cls_t    s_cls;
        logic [9:0]  h_man;
        logic [14:0] s_sub;
    } shf_t;

    // Number of left shifts that bring the leading one of a non-zero
    // half mantissa up to the hidden bit position.
    function automatic logic [3:0] half_lz(input logic [9:0] man);
        logic [3:0] lz;
        lz = 4'd10;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                lz = 4'(10 - i);
            end
        end
        return lz;
    endfunction

endpackage

// ----- src/hbs_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_decode
// First stage: classifies the source and works out shift amounts.
// ----------------------------------------------------------------------------
module hbs_decode
    import hbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [1:0]  op,
    input  logic [31:0] value_bits,
    output dec_t        dec
);

    logic       valid_reg;
    logic       valid_next;
    dec_t       data_reg;
    dec_t       data_next;
    logic [7:0] s_exp;
    logic [7:0] sh_full;

    always_comb
    begin
        s_exp   = value_bits[30:23];
        sh_full = S2H_SHIFT_BASE - s_exp;
        valid_next      = take;
        data_next       = '0;
        data_next.valid = take;
        data_next.op    = op_t'(op);
        data_next.val   = value_bits;
        data_next.h_lz  = half_lz(value_bits[9:0]);
        data_next.s_sh  = sh_full[4:0];
        priority if (s_exp < S2H_SUB_MIN_EXP)
            data_next.s_cls = S2H_ZERO;
        else if (s_exp <= REBIAS)
            data_next.s_cls = S2H_SUB;
        else if (s_exp >= S2H_OVF_EXP)
            data_next.s_cls = S2H_INF;
        else
            data_next.s_cls = S2H_NORM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dec       = data_reg;
        dec.valid = valid_reg;
    end

endmodule

// ----- src/hbs_shift.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_shift
// Second stage: normalises half subnormals and denormalises single inputs.
// ----------------------------------------------------------------------------
module hbs_shift
    import hbs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  dec_t dec,
    output shf_t shf
);

    logic        valid_reg;
    logic        valid_next;
    shf_t        data_reg;
    shf_t        data_next;
    logic [10:0] h_wide;
    logic [23:0] s_wide;

    always_comb
    begin
        h_wide = {1'b0, dec.val[9:0]} << dec.h_lz;
        s_wide = {1'b1, dec.val[22:0]} >> dec.s_sh;
        valid_next      = dec.valid;
        data_next.valid = dec.valid;
        data_next.op    = dec.op;
        data_next.val   = dec.val;
        data_next.h_lz  = dec.h_lz;
        data_next.s_cls = dec.s_cls;
        data_next.h_man = h_wide[9:0];
        data_next.s_sub = s_wide[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        shf       = data_reg;
        shf.valid = valid_reg;
    end

endmodule

// ----- src/hbs_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pack
// Third stage: assembles the result pattern and drives the output register.
// ----------------------------------------------------------------------------
module hbs_pack
    import hbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  shf_t        shf,
    output logic        done,
    output logic [31:0] result_bits
);

    logic        done_reg;
    logic        done_next;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic        h_sign;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [7:0]  s_exp;
    logic [7:0]  rebiased;
    logic [14:0] half_mag;

    always_comb
    begin
        h_sign   = shf.val[15];
        h_exp    = shf.val[14:10];
        h_man    = shf.val[9:0];
        s_exp    = shf.val[30:23];
        rebiased = s_exp - REBIAS;
        unique case (shf.s_cls)
            S2H_ZERO: half_mag = '0;
            S2H_SUB:  half_mag = shf.s_sub;
            S2H_NORM: half_mag = {rebiased[4:0], shf.val[22:13]};
            default:  half_mag = HALF_INF_MAG;
        endcase
        unique case (shf.op)
            OP_H2S:
            begin
                priority if (h_exp == '0 && h_man == '0)
                    result_next = {h_sign, 31'd0};
                else if (h_exp == '0)
                    result_next = {h_sign, SUB_EXP_BASE - {4'd0, shf.h_lz},
                                   shf.h_man, 13'd0};
                else if (h_exp == HALF_EXP_MAX)
                    result_next = {h_sign, SINGLE_EXP_MAX, h_man, 13'd0};
                else
                    result_next = {h_sign, {3'd0, h_exp} + REBIAS, h_man, 13'd0};
            end
            OP_S2H:  result_next = {16'd0, shf.val[31], half_mag};
            OP_B2S:  result_next = {shf.val[15:0], 16'd0};
            default: result_next = {16'd0, shf.val[31:16]};
        endcase
        done_next = shf.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done        = done_reg;
    assign result_bits = result_reg;

endmodule

// ----- src/half_bfloat_single_converter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_bfloat_single_converter_top
// Converts between half, bfloat16 and single bit patterns.
// Requests pass through three registered stages, decode, shift and pack, and the
// done strobe rises together with the registered result.
// Throughput is one request per cycle; busy is never raised.
// Reset clears the stage valid bits, so no strobe follows reset.
// The receiver cannot stall, and every result is strobed for one cycle.
// ----------------------------------------------------------------------------
module half_bfloat_single_converter_top
    import hbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] value_bits,
    output logic        done,
    output logic [31:0] result_bits
);

    dec_t dec;
    shf_t shf;

    assign busy = 1'b0;

    hbs_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (start & ~busy),
        .op         (op),
        .value_bits (value_bits),
        .dec        (dec)
    );

    hbs_shift u_shift
    (
        .clk   (clk),
        .rst_n (rst_n),
        .dec   (dec),
        .shf   (shf)
    );

    hbs_pack u_pack
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .shf         (shf),
        .done        (done),
        .result_bits (result_bits)
    );

endmodule

// ----- sim/half_bfloat_single_converter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_bfloat_single_converter_checker
// Watches the request and result channels of the converter, works out the
// converted pattern of every accepted request and compares each strobed
// result, in order, against the oldest pattern still awaited.
// ----------------------------------------------------------------------------
module half_bfloat_single_converter_checker
    import hbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] value_bits,
    input  logic        done,
    input  logic [31:0] result_bits,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam int AWAIT_DEPTH = 16;

    typedef struct {
        op_t         code;
        logic [31:0] source;
        logic [31:0] converted;
    } conversion_t;

    conversion_t awaited_conversions[AWAIT_DEPTH];
    logic [3:0]  head_idx;
    logic [3:0]  tail_idx;
    int unsigned awaited_count;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        head_idx      = 4'd0;
        tail_idx      = 4'd0;
        awaited_count = 0;
    end

    function automatic logic [31:0] half_to_single_bits(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [10:0] norm;
        int          lead;
        sign = {h[15], 31'b0};
        ex   = h[14:10];
        man  = h[9:0];
        lead = 0;
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                return sign;
            end
            for (int i = 0; i < 10; i++)
            begin
                if (man[i])
                begin
                    lead = i;
                end
            end
            norm = {1'b0, man} << (10 - lead);
            return sign | (32'(103 + lead) << 23) | (32'(norm[9:0]) << 13);
        end
        if (ex == HALF_EXP_MAX)
        begin
            return sign | 32'h7F80_0000 | (32'(man) << 13);
        end
        return sign | (32'(ex + 8'd112) << 23) | (32'(man) << 13);
    endfunction

    function automatic logic [15:0] single_to_half_bits(input logic [31:0] s);
        logic [15:0] sign;
        logic [23:0] full;
        int          ex;
        sign = {s[31], 15'b0};
        ex   = int'(s[30:23]) - 112;
        if (ex <= 0)
        begin
            if (ex < -10)
            begin
                return sign;
            end
            full = {1'b1, s[22:0]};
            return sign | 16'(full >> (14 - ex));
        end
        if (ex >= 31)
        begin
            return sign | {1'b0, HALF_INF_MAG};
        end
        return sign | 16'(ex << 10) | 16'(s[22:13]);
    endfunction

    function automatic logic [31:0] converted_pattern(input op_t code,
                                                      input logic [31:0] v);
        case (code)
            OP_H2S:  return half_to_single_bits(v[15:0]);
            OP_S2H:  return {16'b0, single_to_half_bits(v)};
            OP_B2S:  return {v[15:0], 16'b0};
            default: return {16'b0, v[31:16]};
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        conversion_t oldest;
        conversion_t fresh;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_count == 0)
                begin
                    report_mismatch($sformatf("result %08h strobed with no request pending",
                                              result_bits));
                end
                else
                begin
                    oldest        = awaited_conversions[head_idx];
                    head_idx      = head_idx + 4'd1;
                    awaited_count = awaited_count - 1;
                    if (result_bits !== oldest.converted)
                    begin
                        report_mismatch($sformatf(
                            "%s of %08h: result_bits %08h, predicted %08h",
                            oldest.code.name(), oldest.source, result_bits,
                            oldest.converted));
                    end
                end
            end
            if (start && !busy)
            begin
                fresh.code      = op_t'(op);
                fresh.source    = value_bits;
                fresh.converted = converted_pattern(op_t'(op), value_bits);
                if (awaited_count == AWAIT_DEPTH)
                begin
                    report_mismatch($sformatf("request %08h accepted with too many pending",
                                              value_bits));
                end
                else
                begin
                    awaited_conversions[tail_idx] = fresh;
                    tail_idx      = tail_idx + 4'd1;
                    awaited_count = awaited_count + 1;
                end
            end
            pending <= awaited_count;
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the half/bfloat16/single converter with directed edge patterns and
// random requests of every class, idling in random bursts, and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb
    import hbs_pkg::*;
();

    localparam int RANDOM_REQUESTS = 1600;
    localparam int STEADY_TAIL     = 200;
    localparam int DRAIN_CYCLES    = 10;
    localparam int IDLE_LIMIT      = 2000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  op          = OP_H2S;
    logic [31:0] value_bits  = 32'd0;
    logic        busy;
    logic        done;
    logic [31:0] result_bits;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned quiet_cycles = 0;

    always #5 clk = ~clk;

    half_bfloat_single_converter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .value_bits  (value_bits),
        .done        (done),
        .result_bits (result_bits)
    );

    half_bfloat_single_converter_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .value_bits  (value_bits),
        .done        (done),
        .result_bits (result_bits),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[half_bfloat_single_converter_top] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input op_t code, input logic [31:0] bits);
        start      <= 1'b1;
        op         <= code;
        value_bits <= bits;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [31:0] random_source(input op_t code);
        logic [31:0] bits;
        logic [9:0]  man;
        logic [7:0]  ex;
        bits = $urandom;
        case (code)
            OP_H2S:
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        bits[14:0] = 15'd0;
                    end
                    1:
                    begin
                        man = 10'($urandom_range(1, 1023)) >> $urandom_range(0, 9);
                        if (man == 10'd0)
                        begin
                            man = 10'd1;
                        end
                        bits[14:0] = {5'd0, man};
                    end
                    2:
                    begin
                        bits[14:10] = 5'($urandom_range(1, 30));
                    end
                    default:
                    begin
                        bits[14:10] = HALF_EXP_MAX;
                    end
                endcase
            end
            OP_S2H:
            begin
                case ($urandom_range(0, 4))
                    0:       ex = 8'($urandom_range(0, 101));
                    1:       ex = 8'($urandom_range(102, 112));
                    2:       ex = 8'($urandom_range(113, 142));
                    3:       ex = 8'($urandom_range(143, 255));
                    default: ex = bits[30:23];
                endcase
                bits[30:23] = ex;
            end
            default:
            begin
            end
        endcase
        return bits;
    endfunction

    initial
    begin
        op_t code;
        int  idle_chance;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_H2S, 32'h0000_0000);
        send_request(OP_H2S, 32'h0000_8000);
        send_request(OP_H2S, 32'h0000_0001);
        send_request(OP_H2S, 32'h0000_83FF);
        send_request(OP_H2S, 32'h0000_0200);
        send_request(OP_H2S, 32'h0000_0400);
        send_request(OP_H2S, 32'h0000_7BFF);
        send_request(OP_H2S, 32'h0000_7C00);
        send_request(OP_H2S, 32'h0000_FE01);
        send_request(OP_H2S, 32'hFFFF_3C00);
        send_request(OP_S2H, 32'h0000_0000);
        send_request(OP_S2H, 32'h8000_0001);
        send_request(OP_S2H, 32'h3300_0000);
        send_request(OP_S2H, 32'h3380_0000);
        send_request(OP_S2H, 32'hB87F_FFFF);
        send_request(OP_S2H, 32'h3880_0000);
        send_request(OP_S2H, 32'h477F_FFFF);
        send_request(OP_S2H, 32'hC780_0000);
        send_request(OP_S2H, 32'h7F80_0000);
        send_request(OP_S2H, 32'hFFC0_0001);
        send_request(OP_B2S, 32'hFFFF_8001);
        send_request(OP_B2S, 32'h0000_7FFF);
        send_request(OP_S2B, 32'hFFFF_FFFF);
        send_request(OP_S2B, 32'h7FC0_0001);
        pause_sender($urandom_range(1, 14));

        idle_chance = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 200 == 0)
            begin
                idle_chance = $urandom_range(0, 2) * 15;
            end
            if (n >= RANDOM_REQUESTS - STEADY_TAIL)
            begin
                idle_chance = 0;
            end
            code = op_t'($urandom_range(0, 3));
            send_request(code, random_source(code));
            if ($urandom_range(1, 100) <= idle_chance)
            begin
                pause_sender($urandom_range(1, 14));
            end
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("[half_bfloat_single_converter_top] OK");
        end
        else
        begin
            $display("[half_bfloat_single_converter_top] ERROR");
        end
        $finish;
    end

endmodule
